[hdl/assert_macros.svh]
// assertion macros used by the port-level checker rnorm_chk
// no dependencies; the caller provides clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clk, off while in reset
`define RN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define RN_ASSERT_IMP(lbl, ante, cons, msg) \
  `RN_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[hdl/rnorm_pkg.sv]
// rational normalizer package: widths, beat types, state encoding, magnitude helper
// no dependencies
`timescale 1ns / 1ps

package rnorm_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAG_W      = DATA_WIDTH - 1;
  localparam int CNT_W      = $clog2(MAG_W);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numer_in;
    logic signed [DATA_WIDTH-1:0] denom_in;
  } rn_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numer_out;
    logic        [MAG_W-1:0]      denom_out;
    logic                         div_zero;
  } rn_out_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_GCD   = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_DIVN  = 5'b01000,
    ST_DIVD  = 5'b10000
  } rn_state_t;

  // magnitude with the most negative value saturated to the largest magnitude
  function automatic logic [MAG_W-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
    logic [DATA_WIDTH-1:0] neg_v;
    logic [MAG_W-1:0]      res;
    neg_v = ~v + DATA_WIDTH'(1);
    if (!v[DATA_WIDTH-1]) begin
      res = v[MAG_W-1:0];
    end else if (v[MAG_W-1:0] == '0) begin
      res = '1;
    end else begin
      res = neg_v[MAG_W-1:0];
    end
    return res;
  endfunction

endpackage

[hdl/rational_normalizer.sv]
// rational normalizer top level: binary gcd and restoring division on one subtractor
// depends on rnorm_pkg
`timescale 1ns / 1ps

// Reduces a signed fraction to lowest terms with a positive denominator. An item is
// taken when start is high and busy is low; the result appears on out_data for one
// cycle with out_valid and cannot be held off. A zero denominator gives 0/1 with
// div_zero set, a zero numerator gives 0/1; both appear in the cycle after the item is
// taken. Otherwise the work uses a single subtract/compare unit and shifts: the binary gcd
// steps, then a doubling per common factor of two to rescale the divisor, then
// bit-serial division for the two quotients; busy stays high until the result is out,
// so no new item is taken before then. The most negative input is saturated to the
// largest magnitude of the same sign.
module rational_normalizer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rnorm_pkg::rn_in_t  in_data,
  output logic             out_valid,
  output rnorm_pkg::rn_out_t out_data
);
  import rnorm_pkg::*;

  rn_state_t        state_r, state_nxt;
  logic [MAG_W-1:0] a_r, a_nxt;
  logic [MAG_W-1:0] b_r, b_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] quo_r, quo_nxt;
  logic [MAG_W-1:0] qn_r, qn_nxt;
  logic [MAG_W-1:0] dm_r, dm_nxt;
  logic             neg_r, neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  rn_out_t          out_r, out_nxt;

  logic [MAG_W-1:0]      in_nmag, in_dmag;
  logic [MAG_W:0]        sub_x, sub_y;
  logic [MAG_W+1:0]      sub_d;
  logic                  sub_borrow;
  logic [MAG_W-1:0]      sub_neg;
  logic [MAG_W-1:0]      div_rem, div_quo;
  logic [DATA_WIDTH-1:0] qn_ext, qn_res;

  assign in_nmag = mag_of(in_data.numer_in);
  assign in_dmag = mag_of(in_data.denom_in);

  // shared subtract/compare unit
  always_comb begin
    if (state_r == ST_GCD) begin
      sub_x = {1'b0, a_r};
    end else begin
      sub_x = {rem_r, quo_r[MAG_W-1]};
    end
    sub_y = {1'b0, (state_r == ST_GCD) ? b_r : a_r};
  end

  assign sub_d      = {1'b0, sub_x} - {1'b0, sub_y};
  assign sub_borrow = sub_d[MAG_W+1];
  assign sub_neg    = ~sub_d[MAG_W-1:0] + MAG_W'(1);

  // one restoring division step
  assign div_rem = sub_borrow ? sub_x[MAG_W-1:0] : sub_d[MAG_W-1:0];
  assign div_quo = {quo_r[MAG_W-2:0], ~sub_borrow};

  assign qn_ext = {1'b0, qn_r};
  assign qn_res = neg_r ? (~qn_ext + DATA_WIDTH'(1)) : qn_ext;

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    qn_nxt        = qn_r;
    dm_nxt        = dm_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt = in_data.numer_in[DATA_WIDTH-1] ^ in_data.denom_in[DATA_WIDTH-1];
          if (in_dmag == '0) begin
            out_valid_nxt     = 1'b1;
            out_nxt.numer_out = '0;
            out_nxt.denom_out = MAG_W'(1);
            out_nxt.div_zero  = 1'b1;
          end else if (in_nmag == '0) begin
            out_valid_nxt     = 1'b1;
            out_nxt.numer_out = '0;
            out_nxt.denom_out = MAG_W'(1);
            out_nxt.div_zero  = 1'b0;
          end else begin
            a_nxt     = in_nmag;
            b_nxt     = in_dmag;
            qn_nxt    = in_nmag;
            dm_nxt    = in_dmag;
            k_nxt     = '0;
            state_nxt = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (sub_d == '0) begin
          state_nxt = ST_SCALE;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + CNT_W'(1);
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (sub_borrow) begin
          b_nxt = sub_neg;
        end else begin
          a_nxt = sub_d[MAG_W-1:0];
        end
      end
      ST_SCALE: begin
        if (k_r == '0) begin
          quo_nxt   = qn_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(MAG_W - 1);
          state_nxt = ST_DIVN;
        end else begin
          a_nxt = a_r << 1;
          k_nxt = k_r - CNT_W'(1);
        end
      end
      ST_DIVN: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          qn_nxt    = div_quo;
          quo_nxt   = dm_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(MAG_W - 1);
          state_nxt = ST_DIVD;
        end
      end
      ST_DIVD: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          out_valid_nxt     = 1'b1;
          out_nxt.numer_out = qn_res;
          out_nxt.denom_out = div_quo;
          out_nxt.div_zero  = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    qn_r  <= qn_nxt;
    dm_r  <= dm_nxt;
    neg_r <= neg_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/rnorm_chk.sv]
// port-level checker for the rational normalizer, bound to the top level
// depends on rnorm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rnorm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input rnorm_pkg::rn_out_t out_data
);
  import rnorm_pkg::*;

  // a result only follows an accepted beat or work in progress
  `RN_ASSERT_IMP(a_out_cause, out_valid, $past(busy || start), "result without a beat")
  // an accepted beat either finishes at once or keeps the block busy
  `RN_ASSERT(a_accept, (start && !busy) |=> (busy || out_valid), "accepted beat lost")
  `RN_ASSERT_IMP(a_denom_pos, out_valid, out_data.denom_out != '0, "zero denominator out")
  `RN_ASSERT_IMP(a_div_zero, out_valid && out_data.div_zero,
                 out_data.numer_out == '0 && out_data.denom_out == MAG_W'(1), "bad 0/1")
  `RN_ASSERT_IMP(a_zero_num, out_valid && out_data.numer_out == '0,
                 out_data.denom_out == MAG_W'(1), "zero numerator not over 1")

endmodule

bind rational_normalizer rnorm_chk u_rnorm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[tb/sv/rnorm_checker.sv]
// checker for the rational normalizer: watches both channels, predicts each reduced fraction
// and compares it field by field with the beat that comes back; depends on rnorm_pkg
`timescale 1ns / 1ps

module rnorm_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  rnorm_pkg::rn_in_t  in_data,
  input  logic               out_valid,
  input  rnorm_pkg::rn_out_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked
);
  import rnorm_pkg::*;

  rn_out_t reduced_q[$];
  rn_out_t oldest;

  function automatic logic [MAG_W-1:0] abs_sat(input logic [DATA_WIDTH-1:0] v,
                                               output logic neg);
    logic [DATA_WIDTH-1:0] flipped;
    neg = v[DATA_WIDTH-1];
    flipped = -v;
    if (!neg) begin
      return v[MAG_W-1:0];
    end else if (flipped[DATA_WIDTH-1]) begin
      return {MAG_W{1'b1}};
    end
    return flipped[MAG_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] euclid_gcd(input logic [MAG_W-1:0] a,
                                                  input logic [MAG_W-1:0] b);
    logic [MAG_W-1:0] x;
    logic [MAG_W-1:0] y;
    logic [MAG_W-1:0] r;
    x = a;
    y = b;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic rn_out_t reduce_fraction(input rn_in_t item);
    logic             nneg;
    logic             dneg;
    logic [MAG_W-1:0] nmag;
    logic [MAG_W-1:0] dmag;
    logic [MAG_W-1:0] g;
    logic [MAG_W-1:0] rn;
    logic [DATA_WIDTH-1:0] wide_n;
    rn_out_t          res;
    nmag = abs_sat(item.numer_in, nneg);
    dmag = abs_sat(item.denom_in, dneg);
    res.numer_out = '0;
    res.denom_out = MAG_W'(1);
    res.div_zero  = 1'b0;
    if (dmag == '0) begin
      res.div_zero = 1'b1;
    end else if (nmag != '0) begin
      g = euclid_gcd(nmag, dmag);
      rn = nmag / g;
      wide_n = {1'b0, rn};
      res.numer_out = (nneg ^ dneg) ? -wide_n : wide_n;
      res.denom_out = dmag / g;
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    results_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reduced_q.delete();
    end else begin
      if (out_valid) begin
        if (reduced_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat %0d/%0d div_zero=%0b", $time,
                   out_data.numer_out, out_data.denom_out, out_data.div_zero);
        end else begin
          oldest = reduced_q.pop_front();
          results_checked++;
          if (out_data.numer_out !== oldest.numer_out) begin
            fail_count++;
            $display("%0t: numer_out expected %0d actual %0d", $time,
                     oldest.numer_out, out_data.numer_out);
          end
          if (out_data.denom_out !== oldest.denom_out) begin
            fail_count++;
            $display("%0t: denom_out expected %0d actual %0d", $time,
                     oldest.denom_out, out_data.denom_out);
          end
          if (out_data.div_zero !== oldest.div_zero) begin
            fail_count++;
            $display("%0t: div_zero expected %0b actual %0b", $time,
                     oldest.div_zero, out_data.div_zero);
          end
        end
      end
      if (start && !busy) begin
        reduced_q.push_back(reduce_fraction(in_data));
      end
    end
    pending = reduced_q.size();
  end

endmodule

[tb/sv/testbench.sv]
// top of the rational normalizer testbench: clock, reset, directed and random fractions
// under three sender idle profiles; depends on rnorm_pkg, rnorm_checker and the block
`timescale 1ns / 1ps

module testbench;
  import rnorm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 200;

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  rn_in_t  in_data;
  logic    out_valid;
  rn_out_t out_data;

  int fail_count;
  int pending;
  int results_checked;
  int stall_cycles;
  int beats_sent;

  rational_normalizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  rnorm_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no beat for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("[rational_normalizer] ERROR");
    $finish;
  end

  function automatic rn_in_t frac(input logic [DATA_WIDTH-1:0] n,
                                  input logic [DATA_WIDTH-1:0] d);
    rn_in_t item;
    item.numer_in = n;
    item.denom_in = d;
    return item;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] rand_sign(input logic [DATA_WIDTH-1:0] v);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] corner_value();
    case ($urandom_range(5))
      0: return 32'sd0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0001;
      default: return 32'h8000_0000;
    endcase
  endfunction

  function automatic rn_in_t random_fraction();
    logic [DATA_WIDTH-1:0] g;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    case ($urandom_range(9))
      0, 1, 2: begin
        return frac($urandom, $urandom);
      end
      3, 4: begin
        g = $urandom_range(1, 65535);
        a = $urandom_range(0, 32767);
        b = $urandom_range(1, 32767);
        return frac(rand_sign(g * a), rand_sign(g * b));
      end
      5: begin
        return frac(rand_sign($urandom_range(0, 20)), rand_sign($urandom_range(0, 20)));
      end
      6: begin
        a = (32'd1 << $urandom_range(0, 15)) * $urandom_range(1, 32767);
        b = (32'd1 << $urandom_range(0, 15)) * $urandom_range(1, 32767);
        return frac(rand_sign(a), rand_sign(b));
      end
      7: begin
        if ($urandom_range(1)) begin
          return frac(corner_value(), $urandom);
        end
        return frac($urandom, corner_value());
      end
      8: begin
        return $urandom_range(1) ? frac($urandom, 32'sd0) : frac(32'sd0, $urandom);
      end
      default: begin
        a = $urandom_range(1, 32'h7fff_ffff);
        return frac(rand_sign(a), rand_sign(a));
      end
    endcase
  endfunction

  task automatic send_beat(input rn_in_t item, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int idle_pct);
    repeat (PHASE_ITEMS) send_beat(random_fraction(), idle_pct);
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    beats_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // signs, zeros, saturation of the most negative value, worst case euclid
    send_beat(frac(32'sd6, 32'sd4), 0);
    send_beat(frac(-32'sd6, 32'sd4), 0);
    send_beat(frac(32'sd6, -32'sd4), 0);
    send_beat(frac(-32'sd6, -32'sd4), 0);
    send_beat(frac(32'sd0, 32'sd5), 0);
    send_beat(frac(32'sd0, -32'sd7), 0);
    send_beat(frac(32'sd5, 32'sd0), 0);
    send_beat(frac(32'sd0, 32'sd0), 0);
    send_beat(frac(32'h8000_0000, 32'sd0), 0);
    send_beat(frac(32'sd1, 32'sd1), 0);
    send_beat(frac(32'h7fff_ffff, 32'h7fff_ffff), 0);
    send_beat(frac(32'h8000_0001, 32'h7fff_ffff), 0);
    send_beat(frac(32'h8000_0000, 32'h8000_0000), 0);
    send_beat(frac(32'h8000_0000, 32'sd7), 0);
    send_beat(frac(32'sd1, 32'h8000_0000), 0);
    send_beat(frac(32'sd1836311903, 32'sd1134903170), 0);
    send_beat(frac(32'sd1134903170, -32'sd1836311903), 0);
    send_beat(frac(32'h4000_0000, 32'h0010_0000), 0);
    send_beat(frac(-32'sh4000_0000, 32'h4000_0000), 0);
    send_beat(frac(32'h7fff_ffff, 32'sd1), 0);
    send_beat(frac(32'sd1, -32'sh7fff_ffff), 0);
    send_beat(frac(32'sd12, 32'sd18), 0);
    send_beat(frac(32'sd1000000, -32'sd999999), 0);
    drain();

    random_phase(23);
    random_phase(72);
    random_phase(0);

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d fractions (%0d checked): sign mixes, zero numerators and denominators,",
             beats_sent, results_checked);
    $display("saturated minimum inputs, shared factors and powers of two, light to heavy gaps");
    if (fail_count == 0 && pending == 0) begin
      $display("[rational_normalizer] OK");
    end else begin
      $display("[rational_normalizer] ERROR");
    end
    $finish;
  end

endmodule

[rational_normalizer.f]
+incdir+hdl
hdl/rnorm_pkg.sv
hdl/rational_normalizer.sv
hdl/rnorm_chk.sv
tb/sv/rnorm_checker.sv
tb/sv/testbench.sv
